// File: hdl/dq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies; imported by dq_front, dq_back, double_ended_queue_top and tb_top
package dq_pkg;

   localparam int DQ_DEPTH = 32;
   localparam int DATA_W   = 32;

   // request function codes
   localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FN_POP_FRONT  = 3'd2;
   localparam logic [2:0] FN_POP_BACK   = 3'd3;
   localparam logic [2:0] FN_DISPLAY    = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // command kinds handed from front to back
   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_SHOW = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic                    at_front;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage

// File: hdl/dq_front.sv
// front end: accepts request beats, decodes the function code and queues commands
// depends on dq_pkg
module dq_front import dq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output cmd_type                  cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       dec_ok;
   logic       push, pop;

   always_comb begin
      dec          = '0;
      dec.value    = req_value;
      dec_ok       = 1'b1;
      case (req_func)
         FN_PUSH_FRONT: begin
            dec.kind     = KIND_PUSH;
            dec.at_front = 1'b1;
         end
         FN_PUSH_BACK: begin
            dec.kind     = KIND_PUSH;
            dec.at_front = 1'b0;
         end
         FN_POP_FRONT: begin
            dec.kind     = KIND_POP;
            dec.at_front = 1'b1;
         end
         FN_POP_BACK: begin
            dec.kind     = KIND_POP;
            dec.at_front = 1'b0;
         end
         FN_DISPLAY: begin
            dec.kind     = KIND_SHOW;
            dec.at_front = 1'b1;
         end
         // unused codes are taken and dropped
         default: dec_ok = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && dec_ok;
   assign pop       = cmd_valid && cmd_ready;
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: hdl/dq_back.sv
// back end: circular element store, front pointer and count, display sequencer
// and the response register; depends on dq_pkg
module dq_back import dq_pkg::*; #(
   parameter int DEPTH = DQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  cmd_type                  cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_IDX  = PW'(DEPTH - 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic              state_ff, state_in;
   logic [PW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free, out_load;
   logic              wr_en, rd_en;
   logic [PW-1:0]     wr_addr, rd_addr;
   logic [PW-1:0]     front_m1, back_new, back_old, addr_next;
   logic [SW-1:0]     sum_new, sum_old;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;

   // wrapped indexes around the circular store
   always_comb begin
      front_m1  = (front_ff == '0) ? LAST_IDX : front_ff - PW'(1);
      addr_next = (addr_ff == LAST_IDX) ? '0 : addr_ff + PW'(1);
      sum_new   = SW'(front_ff) + SW'(count_ff);
      sum_old   = sum_new - SW'(1);
      if (sum_new >= DEPTH_S) begin
         sum_new = sum_new - DEPTH_S;
      end
      if (sum_old >= DEPTH_S) begin
         sum_old = sum_old - DEPTH_S;
      end
      back_new = sum_new[PW-1:0];
      back_old = sum_old[PW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      wr_en         = 1'b0;
      wr_addr       = back_new;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      out_load      = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               case (cmd.kind)
                  KIND_PUSH: begin
                     out_load = 1'b1;
                     if (count_ff == DEPTH_C) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (cmd.at_front) begin
                           wr_addr  = front_m1;
                           front_in = front_m1;
                        end
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        out_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rem_in   = CW'(1);
                        count_in = count_ff - CW'(1);
                        state_in = S_READ;
                        if (cmd.at_front) begin
                           front_in = (front_ff == LAST_IDX) ? '0 : front_ff + PW'(1);
                        end else begin
                           rd_addr = back_old;
                        end
                     end
                  end
                  KIND_SHOW: begin
                     if (count_ff == '0) begin
                        out_load      = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        addr_in  = front_ff;
                        rem_in   = count_ff;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_data_in = rd_data_ff;
               rsp_last_in = (rem_ff == CW'(1));
               if (rem_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  // stream the next element while this one goes out
                  rd_en   = 1'b1;
                  rd_addr = addr_next;
                  addr_in = addr_next;
                  rem_in  = rem_ff - CW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
      if (out_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: hdl/double_ended_queue_top.sv
// double_ended_queue_top: bounded deque of signed 32-bit values
// path: every result passes the command queue and the response register; popped and
// displayed elements also pass the registered store read between them
// throughput: one push per cycle, display one element per cycle after the first, both
// while the receiver does not stall; no new command is taken while a store read runs
// reset (synchronous): queue empty, front pointer 0, command queue and response cleared
module double_ended_queue_top import dq_pkg::*; #(
   parameter int DEPTH = DQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   dq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for double_ended_queue_top, with random idling on both channels
// depends on dq_pkg and double_ended_queue_top; predicts every response beat from a shadow deque
module tb_top;
   import dq_pkg::*;

   // func codes that the block ignores
   localparam logic [2:0] FN_RSVD_5 = 3'd5;
   localparam logic [2:0] FN_RSVD_6 = 3'd6;
   localparam logic [2:0] FN_RSVD_7 = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [1:0]               status;
      logic                     last;
   } rsp_beat_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_func  = FN_PUSH_BACK;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_data;
   logic [1:0]               rsp_status;
   logic                     rsp_last;

   // shadow deque
   logic signed [DATA_W-1:0] shadow_store [DQ_DEPTH];
   int                       front_slot = 0;
   int                       held_count = 0;
   rsp_beat_type             expected_beats [$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   bit pace_idle     = 1'b1;
   int rsp_hold_req  = 0;
   int rsp_stall_left = 0;

   double_ended_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   always #2 clock = ~clock;

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void expect_beat(logic signed [DATA_W-1:0] data, logic [1:0] status,
                                       logic last);
      rsp_beat_type beat;
      beat.data   = data;
      beat.status = status;
      beat.last   = last;
      expected_beats.push_back(beat);
   endfunction

   function automatic void predict_deque(logic [2:0] func, logic signed [DATA_W-1:0] value);
      int slot;
      case (func)
         FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (held_count >= DQ_DEPTH) begin
               expect_beat('0, ST_FULL, 1'b1);
            end else begin
               if (func == FN_PUSH_FRONT) begin
                  front_slot = (front_slot + DQ_DEPTH - 1) % DQ_DEPTH;
                  slot = front_slot;
               end else begin
                  slot = (front_slot + held_count) % DQ_DEPTH;
               end
               shadow_store[slot] = value;
               held_count++;
               expect_beat('0, ST_OK, 1'b1);
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (held_count == 0) begin
               expect_beat('0, ST_EMPTY, 1'b1);
            end else begin
               if (func == FN_POP_FRONT) begin
                  slot = front_slot;
                  front_slot = (front_slot + 1) % DQ_DEPTH;
               end else begin
                  slot = (front_slot + held_count - 1) % DQ_DEPTH;
               end
               held_count--;
               expect_beat(shadow_store[slot], ST_OK, 1'b1);
            end
         end
         FN_DISPLAY: begin
            if (held_count == 0) begin
               expect_beat('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < held_count; i++)
                  expect_beat(shadow_store[(front_slot + i) % DQ_DEPTH], ST_OK,
                              i == held_count - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // request beats feed the shadow deque before response beats are checked
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_deque(req_func, req_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected response beat, actual data %0d status %0d last %0b",
                        $time, rsp_data, rsp_status, rsp_last);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data !== want.data) begin
                  $display("%0t: rsp_data mismatch, expected %0d, actual %0d",
                           $time, want.data, rsp_data);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: rsp_status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: rsp_last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats still expected",
                     $time, expected_beats.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver: random stalls, or a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else if (rsp_hold_req > 0) begin
         rsp_stall_left = rsp_hold_req - 1;
         rsp_hold_req = 0;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall_left = pace_idle ? pick_gap() : 0;
         rsp_ready <= (rsp_stall_left == 0);
         if (rsp_stall_left > 0) rsp_stall_left--;
      end
   end

   // valid stays up across back-to-back items; only dropped for a gap or a drain
   task automatic send_request(input logic [2:0] func, input logic signed [DATA_W-1:0] value);
      int gap;
      gap = pace_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_queue();
      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_DISPLAY, pick_value());
      send_request(FN_RSVD_5, pick_value());
      send_request(FN_RSVD_6, pick_value());
      send_request(FN_RSVD_7, pick_value());
      drain_responses();
   endtask

   task automatic test_push_pop_extremes();
      send_request(FN_PUSH_FRONT, 32'sh7fff_ffff);
      send_request(FN_PUSH_BACK, 32'sh8000_0000);
      send_request(FN_PUSH_FRONT, '0);
      send_request(FN_PUSH_BACK, '1);
      send_request(FN_PUSH_FRONT, 32'sh5555_5555);
      send_request(FN_PUSH_BACK, 32'shaaaa_aaaa);
      send_request(FN_DISPLAY, '0);
      send_request(FN_POP_FRONT, '1);
      send_request(FN_POP_BACK, '0);
      send_request(FN_DISPLAY, '1);
      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_POP_FRONT, pick_value());
      send_request(FN_POP_BACK, pick_value());
      send_request(FN_POP_BACK, pick_value());
      drain_responses();
   endtask

   // fill past the top so both push flavors hit full, then empty it again
   task automatic test_fill_and_overflow();
      for (int i = 0; i < DQ_DEPTH; i++)
         send_request(i % 2 ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value());
      send_request(FN_PUSH_FRONT, pick_value());
      send_request(FN_PUSH_BACK, pick_value());
      send_request(FN_DISPLAY, pick_value());
      for (int i = 0; i <= DQ_DEPTH; i++)
         send_request($urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT, pick_value());
      drain_responses();
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      pace_idle = 1'b0;
      rsp_hold_req = 80;
      for (int i = 0; i < 12; i++)
         send_request($urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value());
      send_request(FN_DISPLAY, pick_value());
      for (int i = 0; i < 6; i++)
         send_request(FN_POP_FRONT, pick_value());
      drain_responses();
      pace_idle = 1'b1;
   endtask

   task automatic test_random_mix(input int item_total, input int push_pct, input bit idle);
      int roll;
      logic [2:0] func;
      pace_idle = idle;
      for (int i = 0; i < item_total; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            func = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
         else if (roll < push_pct + 8)
            func = FN_DISPLAY;
         else if (roll < push_pct + 12)
            func = 3'($urandom_range(FN_RSVD_5, FN_RSVD_7));
         else
            func = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
         send_request(func, pick_value());
      end
      drain_responses();
      pace_idle = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_push_pop_extremes();
      test_fill_and_overflow();
      test_backpressure();
      test_random_mix(8, 70, 1'b1);
      test_random_mix(8, 25, 1'b1);
      test_random_mix(5, 50, 1'b0);
      test_random_mix(6, 55, 1'b1);
      if (expected_beats.size() != 0) begin
         $display("%0t: %0d expected response beats never arrived",
                  $time, expected_beats.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: double_ended_queue_top.f
hdl/dq_pkg.sv
hdl/dq_front.sv
hdl/dq_back.sv
hdl/double_ended_queue_top.sv
tb/tb_top.sv
